// File: rtl/bracket_comment_balance_checker_assert.svh
// Assertion macros for the bracket and comment balance checker.
// Used by the control module; the checks vanish when SYNTHESIS is defined.
`ifndef BRACKET_COMMENT_BALANCE_CHECKER_ASSERT_SVH
`define BRACKET_COMMENT_BALANCE_CHECKER_ASSERT_SVH
`ifndef SYNTHESIS
// check on every clock edge, muted while reset is asserted
`define BCBC_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("bcbc assertion failed");
// check on every clock edge, reset included
`define BCBC_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("bcbc assertion failed");
`else
`define BCBC_ASSERT(label, prop)
`define BCBC_ASSERT_ALWAYS(label, prop)
`endif
`endif

// File: rtl/bcbc_pkg.sv
// Shared types and constants of the bracket and comment balance checker.
// No dependencies.
package bcbc_pkg;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} bcbc_text_t;

	typedef struct packed {
		logic [1:0] verdict;
		logic [1:0] symbol_kind;
	} bcbc_result_t;

	// one stack operation, fanned out to every cell
	typedef struct packed {
		logic       push;
		logic       pop;
		logic [1:0] kind;
	} bcbc_stack_op_t;

	typedef enum logic [2:0] {
		MARK_NONE  = 3'b001,
		MARK_SLASH = 3'b010,
		MARK_STAR  = 3'b100
	} bcbc_mark_t;

	localparam logic [1:0] KIND_PAREN   = 2'd0;
	localparam logic [1:0] KIND_SQUARE  = 2'd1;
	localparam logic [1:0] KIND_BRACE   = 2'd2;
	localparam logic [1:0] KIND_COMMENT = 2'd3;

	localparam logic [1:0] V_OK        = 2'd0;
	localparam logic [1:0] V_UNCLOSED  = 2'd1;
	localparam logic [1:0] V_NO_OPENER = 2'd2;
	localparam logic [1:0] V_OVERFLOW  = 2'd3;

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LSQ    = 8'h5B;
	localparam logic [7:0] CH_RSQ    = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;

endpackage

// File: rtl/bracket_comment_balance_checker.sv
// Bracket and comment balance checker.
// Channel text: one byte per transfer with valid/stall; end_of_text set
// closes the text and asks for the verdict (the byte is then ignored).
// Channel result: one verdict/symbol_kind transfer per end-of-text item,
// nothing for ordinary bytes.
// Throughput: one item per cycle while text_stall is low; each byte is
// decoded and its push or pop applied to the shift stack in the cycle
// it is accepted. The registered verdict shows in the cycle after end_of_text.
// Stack: STACK_DEPTH cells in a row; a push shifts every entry one cell
// down, a pop one cell up, so the top is always in cell 0.
// Reset (arst_n low): no pending mark, empty stack, no error, no result.
// Stalling: text_stall is high while a result is held and result_stall is
// high; the held result does not change until it is taken.
// Depends on bcbc_pkg, bcbc_ctrl and bcbc_cell.
module bracket_comment_balance_checker #(
	parameter int STACK_DEPTH = 128
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   text_valid,
	output logic                   text_stall,
	input  bcbc_pkg::bcbc_text_t   text,
	output logic                   result_valid,
	input  logic                   result_stall,
	output bcbc_pkg::bcbc_result_t result
);

	bcbc_pkg::bcbc_stack_op_t op;
	logic [1:0]               kind_row [STACK_DEPTH];

	bcbc_ctrl #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_valid),
		.text_stall   (text_stall),
		.text         (text),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.top_kind     (kind_row[0]),
		.op           (op)
	);

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [1:0] above, below;
		if (i == 0) begin : g_top
			assign above = op.kind;
		end else begin : g_mid
			assign above = kind_row[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_bottom
			assign below = kind_row[i];
		end else begin : g_inner
			assign below = kind_row[i+1];
		end
		bcbc_cell u_cell (
			.clk        (clk),
			.op         (op),
			.above_kind (above),
			.below_kind (below),
			.kind_q     (kind_row[i])
		);
	end

endmodule

// File: rtl/bcbc_cell.sv
// One entry of the shift stack: takes the entry above on a push and the
// entry below on a pop. Depends on bcbc_pkg.
module bcbc_cell (
	input  logic                    clk,
	input  bcbc_pkg::bcbc_stack_op_t op,
	input  logic [1:0]              above_kind,
	input  logic [1:0]              below_kind,
	output logic [1:0]              kind_q
);

	always_ff @(posedge clk) begin
		if (op.push) begin
			kind_q <= above_kind;
		end else if (op.pop) begin
			kind_q <= below_kind;
		end
	end

endmodule

// File: rtl/bcbc_ctrl.sv
// Tokenizer, depth counter, error latch and result register.
// Depends on bcbc_pkg and bracket_comment_balance_checker_assert.svh.
`include "bracket_comment_balance_checker_assert.svh"
module bcbc_ctrl #(
	parameter int STACK_DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     text_valid,
	output logic                     text_stall,
	input  bcbc_pkg::bcbc_text_t     text,
	output logic                     result_valid,
	input  logic                     result_stall,
	output bcbc_pkg::bcbc_result_t   result,
	input  logic [1:0]               top_kind,
	output bcbc_pkg::bcbc_stack_op_t op
);

	localparam int DW = $clog2(STACK_DEPTH + 1);

	bcbc_pkg::bcbc_mark_t   mark_q, mark_d;
	logic [DW-1:0]          depth_q, depth_d;
	logic                   err_q, err_d;
	logic [1:0]             err_verdict_q, err_verdict_d;
	logic [1:0]             err_kind_q, err_kind_d;
	logic                   out_valid_q;
	bcbc_pkg::bcbc_result_t out_q;

	logic                   accept, is_eot;
	logic                   tok_valid, tok_open;
	logic [1:0]             tok_kind;
	logic                   empty, full;
	bcbc_pkg::bcbc_result_t verdict_now;

	assign text_stall   = out_valid_q & result_stall;
	assign accept       = text_valid & ~text_stall;
	assign is_eot       = accept & text.end_of_text;
	assign empty        = (depth_q == '0);
	assign full         = (depth_q == DW'(STACK_DEPTH));
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// tokenizer: a pending mark pairs with this byte or is dropped
	always_comb begin
		tok_valid = 1'b0;
		tok_open  = 1'b0;
		tok_kind  = bcbc_pkg::KIND_PAREN;
		mark_d    = bcbc_pkg::MARK_NONE;
		if (mark_q == bcbc_pkg::MARK_SLASH && text.text_byte == bcbc_pkg::CH_STAR) begin
			tok_valid = 1'b1;
			tok_open  = 1'b1;
			tok_kind  = bcbc_pkg::KIND_COMMENT;
		end else if (mark_q == bcbc_pkg::MARK_STAR &&
				text.text_byte == bcbc_pkg::CH_SLASH) begin
			tok_valid = 1'b1;
			tok_kind  = bcbc_pkg::KIND_COMMENT;
		end else begin
			unique case (text.text_byte)
				bcbc_pkg::CH_LPAREN: begin
					tok_valid = 1'b1;
					tok_open  = 1'b1;
				end
				bcbc_pkg::CH_RPAREN: begin
					tok_valid = 1'b1;
				end
				bcbc_pkg::CH_LSQ: begin
					tok_valid = 1'b1;
					tok_open  = 1'b1;
					tok_kind  = bcbc_pkg::KIND_SQUARE;
				end
				bcbc_pkg::CH_RSQ: begin
					tok_valid = 1'b1;
					tok_kind  = bcbc_pkg::KIND_SQUARE;
				end
				bcbc_pkg::CH_LBRACE: begin
					tok_valid = 1'b1;
					tok_open  = 1'b1;
					tok_kind  = bcbc_pkg::KIND_BRACE;
				end
				bcbc_pkg::CH_RBRACE: begin
					tok_valid = 1'b1;
					tok_kind  = bcbc_pkg::KIND_BRACE;
				end
				bcbc_pkg::CH_SLASH: mark_d = bcbc_pkg::MARK_SLASH;
				bcbc_pkg::CH_STAR:  mark_d = bcbc_pkg::MARK_STAR;
				default: ;
			endcase
		end
	end

	// stack action and first-error latch
	always_comb begin
		op            = '0;
		op.kind       = tok_kind;
		depth_d       = depth_q;
		err_d         = err_q;
		err_verdict_d = err_verdict_q;
		err_kind_d    = err_kind_q;
		if (accept && !text.end_of_text && tok_valid && !err_q) begin
			if (tok_open) begin
				if (full) begin
					err_d         = 1'b1;
					err_verdict_d = bcbc_pkg::V_OVERFLOW;
					err_kind_d    = tok_kind;
				end else begin
					op.push = 1'b1;
					depth_d = depth_q + DW'(1);
				end
			end else if (empty) begin
				err_d         = 1'b1;
				err_verdict_d = bcbc_pkg::V_NO_OPENER;
				err_kind_d    = tok_kind;
			end else if (top_kind == tok_kind) begin
				op.pop  = 1'b1;
				depth_d = depth_q - DW'(1);
			end else begin
				err_d         = 1'b1;
				err_verdict_d = bcbc_pkg::V_UNCLOSED;
				err_kind_d    = top_kind;
			end
		end
	end

	always_comb begin
		verdict_now.verdict     = bcbc_pkg::V_OK;
		verdict_now.symbol_kind = bcbc_pkg::KIND_PAREN;
		if (err_q) begin
			verdict_now.verdict     = err_verdict_q;
			verdict_now.symbol_kind = err_kind_q;
		end else if (!empty) begin
			verdict_now.verdict     = bcbc_pkg::V_UNCLOSED;
			verdict_now.symbol_kind = top_kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q        <= bcbc_pkg::MARK_NONE;
			depth_q       <= '0;
			err_q         <= 1'b0;
			err_verdict_q <= bcbc_pkg::V_OK;
			err_kind_q    <= bcbc_pkg::KIND_PAREN;
			out_valid_q   <= 1'b0;
		end else begin
			if (is_eot) begin
				mark_q        <= bcbc_pkg::MARK_NONE;
				depth_q       <= '0;
				err_q         <= 1'b0;
				err_verdict_q <= bcbc_pkg::V_OK;
				err_kind_q    <= bcbc_pkg::KIND_PAREN;
			end else if (accept) begin
				mark_q        <= mark_d;
				depth_q       <= depth_d;
				err_q         <= err_d;
				err_verdict_q <= err_verdict_d;
				err_kind_q    <= err_kind_d;
			end
			if (is_eot) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_eot) begin
			out_q <= verdict_now;
		end
	end

	`BCBC_ASSERT(a_depth_bound, depth_q <= DW'(STACK_DEPTH))
	`BCBC_ASSERT(a_eot_clears, is_eot |=> depth_q == '0 && !err_q && result_valid)
	`BCBC_ASSERT(a_push_grows, op.push |=> depth_q == $past(depth_q) + DW'(1))
	`BCBC_ASSERT(a_err_sticks, err_q && !is_eot |=> err_q && $stable(err_kind_q))
	`BCBC_ASSERT(a_no_op_on_err, err_q |-> !op.push && !op.pop)

endmodule

// File: tb/testbench.sv
// Self-checking testbench for bracket_comment_balance_checker.
// Holds a predictor of the bracket and comment stack, drives text bytes and end-of-text
// items over valid/stall, and checks every verdict transfer. Depends on bcbc_pkg.
`timescale 1ns / 1ps

module testbench;

	localparam int STACK_DEPTH = 128;
	localparam int CYCLE_LIMIT = 400000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   text_valid = 1'b0;
	logic                   text_stall;
	bcbc_pkg::bcbc_text_t   text = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	bcbc_pkg::bcbc_result_t result;

	bracket_comment_balance_checker #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.text(text),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #10 clk = ~clk;

	// predictor state
	bcbc_pkg::bcbc_mark_t scan_mark = bcbc_pkg::MARK_NONE;
	logic [1:0] nest_kinds [0:STACK_DEPTH-1];
	int         nest_depth = 0;
	logic       err_seen = 1'b0;
	logic [1:0] err_verdict = bcbc_pkg::V_OK;
	logic [1:0] err_kind = bcbc_pkg::KIND_PAREN;

	bcbc_pkg::bcbc_text_t   pending_text [$];
	bcbc_pkg::bcbc_result_t awaited_verdicts [$];
	int  items_queued = 0;
	int  mismatches = 0;
	int  cycles = 0;
	int  send_gap = 0;
	int  stall_left = 0;
	logic calm = 1'b0;

	function automatic void clear_scan();
		scan_mark = bcbc_pkg::MARK_NONE;
		nest_depth = 0;
		err_seen = 1'b0;
		err_verdict = bcbc_pkg::V_OK;
		err_kind = bcbc_pkg::KIND_PAREN;
	endfunction

	function automatic void latch_error(logic [1:0] v, logic [1:0] k);
		err_seen = 1'b1;
		err_verdict = v;
		err_kind = k;
	endfunction

	function automatic void tally_token(logic opener, logic [1:0] kind);
		if (err_seen)
			return;
		if (opener) begin
			if (nest_depth >= STACK_DEPTH) begin
				latch_error(bcbc_pkg::V_OVERFLOW, kind);
			end else begin
				nest_kinds[nest_depth] = kind;
				nest_depth++;
			end
		end else if (nest_depth == 0) begin
			latch_error(bcbc_pkg::V_NO_OPENER, kind);
		end else if (nest_kinds[nest_depth-1] == kind) begin
			nest_depth--;
		end else begin
			latch_error(bcbc_pkg::V_UNCLOSED, nest_kinds[nest_depth-1]);
		end
	endfunction

	function automatic void scan_byte(logic [7:0] b);
		bcbc_pkg::bcbc_mark_t prev;
		prev = scan_mark;
		scan_mark = bcbc_pkg::MARK_NONE;
		if (prev == bcbc_pkg::MARK_SLASH && b == bcbc_pkg::CH_STAR) begin
			tally_token(1'b1, bcbc_pkg::KIND_COMMENT);
		end else if (prev == bcbc_pkg::MARK_STAR && b == bcbc_pkg::CH_SLASH) begin
			tally_token(1'b0, bcbc_pkg::KIND_COMMENT);
		end else begin
			case (b)
				bcbc_pkg::CH_LPAREN: tally_token(1'b1, bcbc_pkg::KIND_PAREN);
				bcbc_pkg::CH_RPAREN: tally_token(1'b0, bcbc_pkg::KIND_PAREN);
				bcbc_pkg::CH_LSQ:    tally_token(1'b1, bcbc_pkg::KIND_SQUARE);
				bcbc_pkg::CH_RSQ:    tally_token(1'b0, bcbc_pkg::KIND_SQUARE);
				bcbc_pkg::CH_LBRACE: tally_token(1'b1, bcbc_pkg::KIND_BRACE);
				bcbc_pkg::CH_RBRACE: tally_token(1'b0, bcbc_pkg::KIND_BRACE);
				bcbc_pkg::CH_SLASH:  scan_mark = bcbc_pkg::MARK_SLASH;
				bcbc_pkg::CH_STAR:   scan_mark = bcbc_pkg::MARK_STAR;
				default: ;
			endcase
		end
	endfunction

	function automatic void predict_transfer(bcbc_pkg::bcbc_text_t t);
		bcbc_pkg::bcbc_result_t r;
		if (!t.end_of_text) begin
			scan_byte(t.text_byte);
			return;
		end
		r.verdict = bcbc_pkg::V_OK;
		r.symbol_kind = bcbc_pkg::KIND_PAREN;
		if (err_seen) begin
			r.verdict = err_verdict;
			r.symbol_kind = err_kind;
		end else if (nest_depth != 0) begin
			r.verdict = bcbc_pkg::V_UNCLOSED;
			r.symbol_kind = nest_kinds[nest_depth-1];
		end
		awaited_verdicts.push_back(r);
		clear_scan();
	endfunction

	// stimulus helpers
	task automatic add_byte(logic [7:0] b);
		bcbc_pkg::bcbc_text_t t;
		t.text_byte = b;
		t.end_of_text = 1'b0;
		pending_text.push_back(t);
		items_queued++;
	endtask

	task automatic add_eot(logic [7:0] b);
		bcbc_pkg::bcbc_text_t t;
		t.text_byte = b;
		t.end_of_text = 1'b1;
		pending_text.push_back(t);
		items_queued++;
	endtask

	task automatic add_str(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task automatic add_token(logic opener, logic [1:0] kind);
		case (kind)
			bcbc_pkg::KIND_PAREN:
				add_byte(opener ? bcbc_pkg::CH_LPAREN : bcbc_pkg::CH_RPAREN);
			bcbc_pkg::KIND_SQUARE:
				add_byte(opener ? bcbc_pkg::CH_LSQ : bcbc_pkg::CH_RSQ);
			bcbc_pkg::KIND_BRACE:
				add_byte(opener ? bcbc_pkg::CH_LBRACE : bcbc_pkg::CH_RBRACE);
			default: begin
				add_byte(opener ? bcbc_pkg::CH_SLASH : bcbc_pkg::CH_STAR);
				add_byte(opener ? bcbc_pkg::CH_STAR : bcbc_pkg::CH_SLASH);
			end
		endcase
	endtask

	function automatic logic [7:0] filler_byte();
		case ($urandom_range(0, 5))
			0: return 8'h0A;
			1: return 8'h20;
			2: return 8'h3C;
			3: return 8'h3E;
			default: return 8'(($urandom_range(8'h61, 8'h7A)));
		endcase
	endfunction

	function automatic logic [7:0] noise_byte();
		logic [7:0] specials [0:8];
		specials = '{bcbc_pkg::CH_LPAREN, bcbc_pkg::CH_RPAREN, bcbc_pkg::CH_LSQ,
			bcbc_pkg::CH_RSQ, bcbc_pkg::CH_LBRACE, bcbc_pkg::CH_RBRACE,
			bcbc_pkg::CH_SLASH, bcbc_pkg::CH_STAR, 8'h0A};
		if ($urandom_range(0, 1))
			return 8'($urandom_range(0, 255));
		return specials[$urandom_range(0, 8)];
	endfunction

	// style: 0 well-formed, 1 broken, 2 noise, 3 deep nesting near the stack limit
	task automatic gen_text(int style);
		logic [1:0] open_kinds [$];
		logic [1:0] k;
		int len;
		int pick;
		len = (style == 3) ? $urandom_range(STACK_DEPTH - 3, STACK_DEPTH + 6)
			: $urandom_range(0, 30);
		for (int i = 0; i < len; i++) begin
			pick = (style == 3) ? 0 : $urandom_range(0, 9);
			if (style == 2) begin
				add_byte(noise_byte());
			end else if (pick <= 3) begin
				k = 2'($urandom_range(0, 3));
				add_token(1'b1, k);
				open_kinds.push_back(k);
			end else if (pick <= 6 && open_kinds.size() > 0) begin
				add_token(1'b0, open_kinds.pop_back());
			end else begin
				add_byte(filler_byte());
			end
		end
		if (style == 1) begin
			case ($urandom_range(0, 3))
				0: ;
				1: add_token(1'b0, 2'($urandom_range(0, 3)));
				2: add_byte(bcbc_pkg::CH_SLASH);
				default: begin
					while (open_kinds.size() > 0)
						add_token(1'b0, open_kinds.pop_back());
					add_token(1'b0, 2'($urandom_range(0, 3)));
				end
			endcase
		end else begin
			while (open_kinds.size() > 0)
				add_token(1'b0, open_kinds.pop_back());
		end
		add_eot(8'($urandom_range(0, 255)));
	endtask

	task automatic gen_random(int target);
		int pick;
		while (items_queued < target) begin
			pick = $urandom_range(0, 39);
			if (pick == 0)
				gen_text(3);
			else if (pick < 25)
				gen_text(0);
			else if (pick < 33)
				gen_text(1);
			else
				gen_text(2);
		end
	endtask

	task automatic wait_drained();
		while (pending_text.size() > 0 || text_valid || awaited_verdicts.size() > 0)
			@(negedge clk);
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (text_valid && !text_stall)
				predict_transfer(text);
			if (!text_valid || !text_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					text_valid <= 1'b0;
				end else if (pending_text.size() > 0) begin
					text <= pending_text.pop_front();
					text_valid <= 1'b1;
					if (!calm && $urandom_range(0, 11) == 0)
						send_gap = $urandom_range(1, 8);
				end else begin
					text_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver stall
	always @(posedge clk) begin
		bcbc_pkg::bcbc_result_t exp_r;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (awaited_verdicts.size() == 0) begin
					$error("result transfer with no verdict pending");
					mismatches++;
				end else begin
					exp_r = awaited_verdicts.pop_front();
					if (result.verdict !== exp_r.verdict) begin
						$error("verdict: expected %0d, actual %0d", exp_r.verdict,
							result.verdict);
						mismatches++;
					end
					if (result.symbol_kind !== exp_r.symbol_kind) begin
						$error("symbol_kind: expected %0d, actual %0d",
							exp_r.symbol_kind, result.symbol_kind);
						mismatches++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 7);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed texts
		add_eot(8'h00);
		add_str("([{/**/}])"); add_eot(8'hFF);
		add_str(")"); add_eot(8'h00);
		add_str("]"); add_eot(8'h00);
		add_str("}"); add_eot(8'h00);
		add_str("*/"); add_eot(8'h00);
		add_str("(]))[/*"); add_eot(8'h00);    // mismatch, later tokens ignored
		add_str("{"); add_eot(8'h00);
		add_str("/\n*/ *"); add_eot(8'h00);     // newline cancels the pending slash
		add_str("**/"); add_eot(8'h00);
		add_str("//*"); add_eot(8'h00);
		add_str("(/"); add_eot(8'h00);          // trailing slash dropped
		add_str("/"); add_eot(8'h00);
		add_str("*"); add_eot(8'h00);
		add_byte(8'h00); add_byte(8'hFF); add_eot(bcbc_pkg::CH_LPAREN);
		add_str("}/"); add_eot(8'h00);          // mark tracking after an error
		for (int i = 0; i < STACK_DEPTH; i++) add_byte(bcbc_pkg::CH_LSQ);
		for (int i = 0; i < STACK_DEPTH; i++) add_byte(bcbc_pkg::CH_RSQ);
		add_eot(8'h00);
		for (int i = 0; i <= STACK_DEPTH; i++) add_byte(bcbc_pkg::CH_LBRACE);
		add_str("/*"); add_eot(8'h00);          // overflow latched
		wait_drained();

		gen_random(items_queued + 900);
		wait_drained();
		calm = 1'b1;
		gen_random(items_queued + 250);
		wait_drained();
		repeat (5) @(negedge clk);

		if (mismatches == 0 && awaited_verdicts.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/bcbc_pkg.sv
rtl/bcbc_cell.sv
rtl/bcbc_ctrl.sv
rtl/bracket_comment_balance_checker.sv
tb/testbench.sv
